// ===== sv/asbc_pkg.sv =====
// Shared types, constants and helper functions of the accumulator stack bytecode core.
// Depends on nothing; the core, its ALU, the checker and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package asbc_pkg;

  // Memory geometry.
  localparam int MEM_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int N_W       = ADDR_W + 1;
  localparam int CFG_W     = 12;
  localparam logic [31:0] DEPTH_LIM  = 32'(MEM_DEPTH);
  localparam logic [31:0] DEPTH_LIM4 = 32'(MEM_DEPTH - 3);

  // Request kinds.
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_RESTART = 2'd1;
  localparam logic [1:0] REQ_STEP    = 2'd2;

  // Core status codes.
  localparam logic [1:0] STAT_RUN   = 2'd0;
  localparam logic [1:0] STAT_HALT  = 2'd1;
  localparam logic [1:0] STAT_BADOP = 2'd2;
  localparam logic [1:0] STAT_FAULT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SBASE  = 2'd0;
  localparam logic [1:0] CFG_RBASE  = 2'd1;
  localparam logic [1:0] CFG_PSTART = 2'd2;

  localparam logic [CFG_W-1:0] SBASE_RST  = 12'd5;
  localparam logic [CFG_W-1:0] RBASE_RST  = 12'd100;
  localparam logic [CFG_W-1:0] PSTART_RST = 12'd256;

  // Opcodes and character classes.
  localparam logic [7:0] OPC_JUMP   = "p";
  localparam logic [7:0] OPC_GETPC  = "P";
  localparam logic [7:0] OPC_SPUSH  = "s";
  localparam logic [7:0] OPC_SPOP   = "S";
  localparam logic [7:0] OPC_DROP   = "D";
  localparam logic [7:0] OPC_ADD    = "+";
  localparam logic [7:0] OPC_SUB    = "-";
  localparam logic [7:0] OPC_AND    = "A";
  localparam logic [7:0] OPC_OR     = "O";
  localparam logic [7:0] OPC_XOR    = "X";
  localparam logic [7:0] OPC_NOT    = "~";
  localparam logic [7:0] OPC_SHL    = "<";
  localparam logic [7:0] OPC_SHR    = ">";
  localparam logic [7:0] OPC_RPUSH  = "r";
  localparam logic [7:0] OPC_RPOP   = "R";
  localparam logic [7:0] OPC_MSTORE = "!";
  localparam logic [7:0] OPC_MLOAD  = "@";
  localparam logic [7:0] OPC_CLR    = "_";
  localparam logic [7:0] OPC_EMIT   = ".";
  localparam logic [7:0] OPC_LOOP   = "[";
  localparam logic [7:0] OPC_ZLOOP  = "Z";
  localparam logic [7:0] OPC_CLOSE  = "]";
  localparam logic [7:0] OPC_BACK   = "C";
  localparam logic [7:0] OPC_SPACE  = " ";
  localparam logic [7:0] OPC_TAB    = 8'h09;
  localparam logic [7:0] OPC_NL     = 8'h0a;
  localparam logic [7:0] OPC_BRK    = "B";
  localparam logic [7:0] OPC_HALT   = "H";
  localparam logic [7:0] CH_D0  = "0";
  localparam logic [7:0] CH_D9  = "9";
  localparam logic [7:0] CH_LA  = "a";
  localparam logic [7:0] CH_LF  = "f";
  localparam logic [7:0] CH_LI  = "i";
  localparam logic [7:0] CH_LN  = "n";
  localparam logic [7:0] CH_UI  = "I";
  localparam logic [7:0] CH_UN  = "N";

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_DECODE, ST_ADJ, ST_SOP, ST_GRD, ST_GACC,
    ST_LOOPD, ST_SCRD, ST_SCCHK, ST_WBCALC, ST_PUT, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] write_addr;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]         out_char;
    logic               char_valid;
    logic [1:0]         run_status;
    logic signed [31:0] accu_now;
    logic signed [31:0] pc_now;
  } res_t;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // Shift one hex character into a value; non-hex characters give odd digits.
  function automatic logic [31:0] hex_in(input logic [31:0] v, input logic [7:0] b);
    logic [31:0] d;
    if (b >= 8'd97 && b < 8'd128) d = {24'b0, b} - 32'd87;
    else d = sext8(b) - 32'd48;
    return {16'b0, v[11:0], 4'b0} | d;
  endfunction

  function automatic logic [7:0] nib_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'b0, n};
    else return 8'h57 + {4'b0, n};
  endfunction

  // Nibble k of a 16-bit value, most significant first.
  function automatic logic [3:0] nib_sel(input logic [15:0] v, input logic [1:0] k);
    case (k)
      2'd0:    return v[15:12];
      2'd1:    return v[11:8];
      2'd2:    return v[7:4];
      default: return v[3:0];
    endcase
  endfunction

  // Leading four hex digits of a value printed with at least four digits.
  function automatic logic [31:0] lead4(input logic [31:0] u);
    if (u[31:16] == 16'd0) return u;
    else if (u[31:20] == 12'd0) return u >> 4;
    else if (u[31:24] == 8'd0) return u >> 8;
    else if (u[31:28] == 4'd0) return u >> 12;
    else return u >> 16;
  endfunction

  function automatic logic in_rng(input logic [31:0] a);
    return a < DEPTH_LIM;
  endfunction

  function automatic logic in_rng4(input logic [31:0] a);
    return a < DEPTH_LIM4;
  endfunction

endpackage

`default_nettype wire

// ===== sv/accumulator_stack_bytecode_core.sv =====
// Top level of the accumulator stack bytecode core: sequencer, registers and instances.
// Depends on asbc_pkg, asbc_ram and asbc_alu.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is taken when start is high and busy is low; its result is shown on
// result for exactly one cycle with done high, and cannot be held off. After reset the
// core clears all MEM_DEPTH (4096) bytes of its memory, one byte a cycle, with busy
// high; configuration writes are taken at any time. A memory write, restart, ignored
// request or a step of a stopped core gives its result in the cycle after acceptance.
// A step needs a fetch and a decode cycle on the single memory read port: simple
// opcodes then end, stack reads adjust the address and read the byte, four-character
// stores write four bytes, loads and taken loops read four (a loop then jumps by a nonzero
// offset), and a loop scan checks each byte it walks, then writes back the offset.

module accumulator_stack_bytecode_core import asbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             req,
  output logic             busy,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output res_t             result
);

  state_t state, state_next;

  logic [CFG_W-1:0] s_base, r_base, p_start;
  logic [31:0] accu, pc, sp, rp;
  logic [31:0] gregs [6];
  logic [1:0]  status;
  logic [7:0]  out_char;
  logic        char_valid;

  logic [7:0]        op_r;
  logic [31:0]       addr, val, off;
  logic [1:0]        k;
  logic [N_W-1:0]    n, depth;
  logic [ADDR_W-1:0] clr_cnt;

  alu_op_t     alu_op;
  logic [31:0] alu_a, alu_b, alu_y;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  logic accept, fwd, taken, is_loop;
  logic [7:0] close_c, open_c;
  logic [31:0] hex_val;

  asbc_ram #(.AW(ADDR_W), .DW(8)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  asbc_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign accept  = start && (state == ST_IDLE);
  assign busy    = (state != ST_IDLE);
  assign done    = (state == ST_DONE);
  assign hex_val = hex_in(val, mem_rdata);

  // Loop direction and condition; in decode the opcode comes straight from memory.
  always_comb begin
    logic [7:0] o;
    o = (state == ST_DECODE) ? mem_rdata : op_r;
    is_loop = (o == OPC_LOOP) || (o == OPC_ZLOOP) || (o == OPC_CLOSE) || (o == OPC_BACK);
    fwd     = (o == OPC_LOOP) || (o == OPC_ZLOOP);
    taken   = (o == OPC_CLOSE) ? (accu != 32'd0) : (accu == 32'd0);
    close_c = fwd ? OPC_CLOSE : OPC_LOOP;
    open_c  = fwd ? OPC_LOOP : OPC_CLOSE;
  end

  assign result.out_char   = out_char;
  assign result.char_valid = char_valid;
  assign result.run_status = status;
  assign result.accu_now   = accu;
  assign result.pc_now     = pc;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, shared unit operands and memory port control.
  always_comb begin
    state_next = state;
    alu_op     = ALU_ADD;
    alu_a      = 32'd0;
    alu_b      = 32'd0;
    mem_we     = 1'b0;
    mem_waddr  = addr[ADDR_W-1:0];
    mem_wdata  = 8'd0;
    mem_raddr  = addr[ADDR_W-1:0];
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        if (clr_cnt == {ADDR_W{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (req.req_type == REQ_WRITE && in_rng({20'b0, req.write_addr})) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(req.write_addr);
            mem_wdata = req.write_byte;
          end
          if (req.req_type == REQ_STEP && status == STAT_RUN) state_next = ST_FETCH;
          else state_next = ST_DONE;
        end
      end
      ST_FETCH: begin
        mem_raddr  = pc[ADDR_W-1:0];
        state_next = in_rng(pc) ? ST_DECODE : ST_DONE;
      end
      ST_DECODE: begin
        state_next = ST_DONE;
        case (mem_rdata)
          OPC_SPUSH: begin
            alu_a = {20'b0, s_base};
            alu_b = sp;
            if (in_rng(alu_y)) begin
              mem_we    = 1'b1;
              mem_waddr = alu_y[ADDR_W-1:0];
              mem_wdata = accu[7:0];
            end
          end
          OPC_SPOP, OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR: begin
            alu_a      = {20'b0, s_base};
            alu_b      = sp;
            state_next = ST_ADJ;
          end
          OPC_RPOP: begin
            alu_a      = {20'b0, r_base};
            alu_b      = rp;
            state_next = ST_ADJ;
          end
          OPC_RPUSH: begin
            alu_a = {20'b0, r_base};
            alu_b = rp;
            if (in_rng4(alu_y)) state_next = ST_PUT;
          end
          OPC_MSTORE: begin
            alu_a = gregs[4];
            alu_b = gregs[0];
            if (in_rng4(alu_y)) state_next = ST_PUT;
          end
          OPC_MLOAD: begin
            alu_a = gregs[4];
            alu_b = gregs[0];
            if (in_rng4(alu_y)) state_next = ST_GRD;
          end
          OPC_LOOP, OPC_ZLOOP, OPC_CLOSE, OPC_BACK: begin
            alu_a = pc;
            alu_b = 32'd1;
            if (taken && in_rng4(alu_y)) state_next = ST_GRD;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_ADJ: begin
        alu_op    = ALU_SUB;
        alu_a     = addr;
        alu_b     = (op_r == OPC_RPOP) ? 32'd4 : 32'd1;
        mem_raddr = alu_y[ADDR_W-1:0];
        if (op_r == OPC_RPOP) state_next = in_rng4(alu_y) ? ST_GRD : ST_DONE;
        else state_next = in_rng(alu_y) ? ST_SOP : ST_DONE;
      end
      ST_SOP: begin
        alu_a = accu;
        alu_b = sext8(mem_rdata);
        case (op_r)
          OPC_SUB: alu_op = ALU_SUB;
          OPC_AND: alu_op = ALU_AND;
          OPC_OR:  alu_op = ALU_OR;
          OPC_XOR: alu_op = ALU_XOR;
          default: alu_op = ALU_ADD;
        endcase
        state_next = ST_DONE;
      end
      ST_GRD: begin
        mem_raddr  = addr[ADDR_W-1:0] + ADDR_W'(k);
        state_next = ST_GACC;
      end
      ST_GACC: begin
        if (k != 2'd3) state_next = ST_GRD;
        else if (is_loop) state_next = ST_LOOPD;
        else state_next = ST_DONE;
      end
      ST_LOOPD: begin
        alu_op = fwd ? ALU_ADD : ALU_SUB;
        alu_a  = pc;
        if (val != 32'd0) begin
          alu_b      = val;
          state_next = ST_DONE;
        end else begin
          alu_b      = fwd ? 32'd5 : 32'd1;
          state_next = ST_SCRD;
        end
      end
      ST_SCRD: begin
        state_next = in_rng(addr) ? ST_SCCHK : ST_DONE;
      end
      ST_SCCHK: begin
        alu_op = fwd ? ALU_ADD : ALU_SUB;
        alu_a  = addr;
        alu_b  = 32'd1;
        if (mem_rdata == close_c && depth == '0) state_next = ST_WBCALC;
        else state_next = ST_SCRD;
      end
      ST_WBCALC: begin
        alu_op     = fwd ? ALU_ADD : ALU_SUB;
        alu_a      = pc;
        alu_b      = off;
        state_next = ST_PUT;
      end
      ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = addr[ADDR_W-1:0] + ADDR_W'(k);
        mem_wdata  = nib_char(nib_sel(val[15:0], k));
        if (k == 2'd3) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_base  <= SBASE_RST;
      r_base  <= RBASE_RST;
      p_start <= PSTART_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SBASE:  s_base  <= cfg_data;
        CFG_RBASE:  r_base  <= cfg_data;
        CFG_PSTART: p_start <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Architectural registers, updated by the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      accu       <= 32'd0;
      pc         <= {20'b0, PSTART_RST};
      sp         <= 32'd0;
      rp         <= 32'd0;
      status     <= STAT_RUN;
      out_char   <= 8'd0;
      char_valid <= 1'b0;
      clr_cnt    <= '0;
      for (int g = 0; g < 6; g++) gregs[g] <= 32'd0;
    end else begin
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            out_char   <= 8'd0;
            char_valid <= 1'b0;
            if (req.req_type == REQ_RESTART) begin
              accu   <= 32'd0;
              pc     <= {20'b0, p_start};
              sp     <= 32'd0;
              rp     <= 32'd0;
              status <= STAT_RUN;
              for (int g = 0; g < 6; g++) gregs[g] <= 32'd0;
            end
          end
        end
        ST_FETCH: begin
          if (!in_rng(pc)) status <= STAT_FAULT;
        end
        ST_DECODE: begin
          case (mem_rdata)
            OPC_JUMP:  pc <= accu;
            OPC_GETPC: begin
              accu <= pc;
              pc   <= pc + 32'd1;
            end
            OPC_SPUSH: begin
              if (in_rng(alu_y)) begin
                sp <= sp + 32'd1;
                pc <= pc + 32'd1;
              end else begin
                status <= STAT_FAULT;
              end
            end
            OPC_DROP: begin
              sp <= sp - 32'd1;
              pc <= pc + 32'd1;
            end
            OPC_NOT: begin
              accu <= {16'b0, ~accu[15:0]};
              pc   <= pc + 32'd1;
            end
            OPC_SHL: begin
              accu <= {accu[30:0], 1'b0};
              pc   <= pc + 32'd1;
            end
            OPC_SHR: begin
              accu <= {accu[31], accu[31:1]};
              pc   <= pc + 32'd1;
            end
            OPC_CLR: begin
              accu <= 32'd0;
              pc   <= pc + 32'd1;
            end
            OPC_EMIT: begin
              out_char   <= accu[7:0];
              char_valid <= 1'b1;
              pc         <= pc + 32'd1;
            end
            OPC_SPOP, OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR, OPC_RPOP: ;
            OPC_RPUSH, OPC_MSTORE, OPC_MLOAD: begin
              if (!in_rng4(alu_y)) status <= STAT_FAULT;
            end
            OPC_LOOP, OPC_ZLOOP, OPC_CLOSE, OPC_BACK: begin
              if (!taken) pc <= pc + 32'd5;
              else if (!in_rng4(alu_y)) status <= STAT_FAULT;
            end
            OPC_SPACE, OPC_TAB, OPC_NL, OPC_BRK: pc <= pc + 32'd1;
            OPC_HALT: status <= STAT_HALT;
            default: begin
              if ((mem_rdata >= CH_D0 && mem_rdata <= CH_D9) ||
                  (mem_rdata >= CH_LA && mem_rdata <= CH_LF)) begin
                accu <= hex_in(accu, mem_rdata);
                pc   <= pc + 32'd1;
              end else if (mem_rdata >= CH_LI && mem_rdata <= CH_LN) begin
                gregs[3'(mem_rdata - CH_LI)] <= accu;
                pc <= pc + 32'd1;
              end else if (mem_rdata >= CH_UI && mem_rdata <= CH_UN) begin
                accu <= gregs[3'(mem_rdata - CH_UI)];
                pc   <= pc + 32'd1;
              end else begin
                status <= STAT_BADOP;
              end
            end
          endcase
        end
        ST_ADJ: begin
          if (op_r == OPC_RPOP) begin
            if (!in_rng4(alu_y)) status <= STAT_FAULT;
          end else if (!in_rng(alu_y)) begin
            status <= STAT_FAULT;
          end
        end
        ST_SOP: begin
          if (op_r == OPC_SPOP) begin
            accu <= sext8(mem_rdata);
            sp   <= sp - 32'd1;
          end else begin
            accu <= alu_y;
          end
          pc <= pc + 32'd1;
        end
        ST_GACC: begin
          if (k == 2'd3) begin
            if (op_r == OPC_RPOP) begin
              accu <= hex_val;
              rp   <= rp - 32'd4;
              pc   <= pc + 32'd1;
            end else if (op_r == OPC_MLOAD) begin
              accu <= hex_val;
              pc   <= pc + 32'd1;
            end
          end
        end
        ST_LOOPD: begin
          if (val != 32'd0) pc <= alu_y;
        end
        ST_SCRD: begin
          if (!in_rng(addr)) status <= STAT_FAULT;
        end
        ST_WBCALC: pc <= alu_y;
        ST_PUT: begin
          if (k == 2'd3) begin
            if (op_r == OPC_RPUSH) begin
              rp <= rp + 32'd4;
              pc <= pc + 32'd1;
            end else if (op_r == OPC_MSTORE) begin
              pc <= pc + 32'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the sequencer; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_DECODE: begin
        op_r <= mem_rdata;
        addr <= alu_y;
        val  <= is_loop ? 32'd0 : accu;
        k    <= 2'd0;
      end
      ST_ADJ: begin
        addr <= alu_y;
        val  <= 32'd0;
      end
      ST_GACC: begin
        val <= hex_val;
        k   <= k + 2'd1;
      end
      ST_LOOPD: begin
        addr  <= alu_y;
        n     <= fwd ? N_W'(5) : N_W'(1);
        depth <= '0;
      end
      ST_SCCHK: begin
        if (mem_rdata == close_c && depth == '0) begin
          off <= fwd ? (32'(n) + 32'd5) : (32'(n) - 32'd5);
        end else begin
          if (mem_rdata == close_c) depth <= depth - 1'b1;
          else if (mem_rdata == open_c) depth <= depth + 1'b1;
          n    <= n + 1'b1;
          addr <= alu_y;
        end
      end
      ST_WBCALC: begin
        val  <= lead4(off);
        addr <= pc + 32'd1;
        k    <= 2'd0;
      end
      ST_PUT: k <= k + 2'd1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/asbc_ram.sv =====
// Byte memory of the core: one write port and one read port with registered read data.
// Generic; sized by its parameters.
`timescale 1ns / 1ps
`default_nettype none

module asbc_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/asbc_alu.sv =====
// Shared 32-bit arithmetic and logic unit of the core.
// Depends on asbc_pkg for the operation codes.
`timescale 1ns / 1ps
`default_nettype none

module asbc_alu import asbc_pkg::*; (
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  // One adder and the bitwise operations, selected by the sequencer.
  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      ALU_AND: y = a & b;
      ALU_OR:  y = a | b;
      ALU_XOR: y = a ^ b;
      default: y = a + b;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/asbc_chk.sv =====
// Port-level checker of the accumulator stack bytecode core, bound to the top level.
// Depends on asbc_pkg for the result type and status codes.
`timescale 1ns / 1ps
`default_nettype none

module asbc_chk import asbc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t result
);

  // An accepted transaction makes the core busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting a transaction");

  // A result strobe lasts one cycle and the core is ready after it.
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe not followed by a ready core");

  // No character is reported without its valid flag.
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.char_valid) |-> (result.out_char == 8'd0))
    else $error("character present without valid flag");

  // A printed character only comes from a running core.
  a_char_run: assert property (@(posedge clk) disable iff (rst)
    (done && result.char_valid) |-> (result.run_status == STAT_RUN))
    else $error("character printed by a stopped core");

endmodule

bind accumulator_stack_bytecode_core asbc_chk u_asbc_chk (.*);

`default_nettype wire

// ===== tb/tb_accumulator_stack_bytecode_core.sv =====
// Self-checking testbench for the accumulator stack bytecode core.
// Depends on asbc_pkg and the RTL of accumulator_stack_bytecode_core; needs nothing else.
`timescale 1ns / 1ps

module tb_accumulator_stack_bytecode_core;
  import asbc_pkg::*;

  // Request kind that the core ignores, and a byte that is no opcode.
  localparam logic [1:0] REQ_NONE   = 2'd3;
  localparam logic [7:0] BAD_OPCODE = "Q";
  localparam int         SETTLE_CYC = 20;

  // Tracks the machine state, predicts each transaction's result and checks it.
  class machine_tracker;
    bit [7:0]  mem [MEM_DEPTH];
    bit [31:0] acc, pc, sp, rp;
    bit [31:0] gr [6];
    bit [1:0]  stat;
    bit [31:0] sbase, rbase, pstart;
    res_t      pending_results [$];
    int        mismatches, results_seen, chars_seen;
    int        stat_seen [4];

    function new();
      foreach (mem[a]) mem[a] = 8'd0;
      sbase  = SBASE_RST;
      rbase  = RBASE_RST;
      pstart = PSTART_RST;
      restart_core();
    endfunction

    function void restart_core();
      acc = 0;
      foreach (gr[k]) gr[k] = 0;
      pc   = pstart;
      sp   = 0;
      rp   = 0;
      stat = STAT_RUN;
    endfunction

    function void set_reg(bit [1:0] idx, bit [11:0] v);
      case (idx)
        CFG_SBASE:  sbase = v;
        CFG_RBASE:  rbase = v;
        CFG_PSTART: pstart = v;
        default: ;
      endcase
    endfunction

    function bit [31:0] widen(bit [7:0] b);
      return {{24{b[7]}}, b};
    endfunction

    // Characters that are not hex digits still give a digit value, possibly negative.
    function bit [31:0] shift_hex(bit [31:0] v, bit [7:0] b);
      bit [31:0] d;
      if (b >= 8'd97 && b < 8'd128) d = {24'd0, b} - 32'd87;
      else d = widen(b) - 32'd48;
      return ((v << 4) & 32'hffff) | d;
    endfunction

    function bit fetch(bit [31:0] a, output bit [7:0] b);
      b = 8'd0;
      if (a >= MEM_DEPTH) return 0;
      b = mem[a];
      return 1;
    endfunction

    function bit get4(bit [31:0] a, output bit [31:0] v);
      bit [31:0] r;
      bit [7:0]  b;
      r = 0;
      v = 0;
      for (int k = 0; k < 4; k++) begin
        if (!fetch(a + k, b)) return 0;
        r = shift_hex(r, b);
      end
      v = r;
      return 1;
    endfunction

    function void put4(bit [31:0] a, bit [31:0] v);
      bit [3:0] nib;
      for (int k = 0; k < 4; k++) begin
        nib = v >> (4 * (3 - k));
        mem[a + k] = (nib < 10) ? 8'h30 + nib : 8'h57 + nib;
      end
    endfunction

    function bit sto4(bit [31:0] a, bit [31:0] v);
      for (int k = 0; k < 4; k++)
        if (a + k >= MEM_DEPTH) return 0;
      put4(a, v);
      return 1;
    endfunction

    function bit [31:0] top4(bit [31:0] u);
      while (u > 32'hffff) u = u >> 4;
      return u;
    endfunction

    // Forward branch; a zero offset scans for the matching close bracket.
    function bit jump_fwd(bit cond);
      bit [31:0] org, d, c, n;
      bit [7:0]  b;
      org = pc;
      c   = 0;
      n   = 5;
      if (!cond) begin
        pc = org + 5;
        return 1;
      end
      if (!get4(org + 1, d)) return 0;
      if (d != 0) begin
        pc = org + d;
        return 1;
      end
      forever begin
        if (!fetch(org + n, b)) return 0;
        if (b == OPC_CLOSE && c == 0) break;
        if (b == OPC_CLOSE) c--;
        else if (b == OPC_LOOP) c++;
        n++;
      end
      put4(org + 1, top4(n + 5));
      pc = org + n + 5;
      return 1;
    endfunction

    // Backward branch; a zero offset scans back for the matching open bracket.
    function bit jump_back(bit cond);
      bit [31:0] org, d, c, n;
      bit [7:0]  b;
      org = pc;
      c   = 0;
      n   = 1;
      if (!cond) begin
        pc = org + 5;
        return 1;
      end
      if (!get4(org + 1, d)) return 0;
      if (d != 0) begin
        pc = org - d;
        return 1;
      end
      forever begin
        if (!fetch(org - n, b)) return 0;
        if (b == OPC_LOOP && c == 0) break;
        if (b == OPC_LOOP) c--;
        else if (b == OPC_CLOSE) c++;
        n++;
      end
      d = n - 5;
      put4(org + 1, top4(d));
      pc = org - d;
      return 1;
    endfunction

    function void run_one(output bit [7:0] chr, output bit vld);
      bit [7:0]  op, b;
      bit [31:0] v;
      bit        adv, ok;
      chr = 0;
      vld = 0;
      adv = 1;
      ok  = 1;
      if (!fetch(pc, op)) begin
        stat = STAT_FAULT;
        return;
      end
      if ((op >= CH_D0 && op <= CH_D9) || (op >= CH_LA && op <= CH_LF)) begin
        acc = shift_hex(acc, op);
      end else if (op >= CH_LI && op <= CH_LN) begin
        gr[op - CH_LI] = acc;
      end else if (op >= CH_UI && op <= CH_UN) begin
        acc = gr[op - CH_UI];
      end else begin
        case (op)
          OPC_JUMP: begin
            pc  = acc;
            adv = 0;
          end
          OPC_GETPC: acc = pc;
          OPC_SPUSH: begin
            v = sbase + sp;
            if (v >= MEM_DEPTH) ok = 0;
            else begin
              mem[v] = acc[7:0];
              sp++;
            end
          end
          OPC_SPOP: begin
            if (!fetch(sbase + sp - 1, b)) ok = 0;
            else begin
              acc = widen(b);
              sp--;
            end
          end
          OPC_DROP: sp--;
          OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR: begin
            if (!fetch(sbase + sp - 1, b)) ok = 0;
            else begin
              v = widen(b);
              case (op)
                OPC_ADD: acc = acc + v;
                OPC_SUB: acc = acc - v;
                OPC_AND: acc = acc & v;
                OPC_OR:  acc = acc | v;
                default: acc = acc ^ v;
              endcase
            end
          end
          OPC_NOT: acc = ~acc & 32'hffff;
          OPC_SHL: acc = acc << 1;
          OPC_SHR: acc = {acc[31], acc[31:1]};
          OPC_CLR: acc = 0;
          OPC_EMIT: begin
            chr = acc[7:0];
            vld = 1;
          end
          OPC_RPUSH: begin
            if (!sto4(rbase + rp, acc)) ok = 0;
            else rp += 4;
          end
          OPC_RPOP: begin
            if (!get4(rbase + rp - 4, v)) ok = 0;
            else begin
              acc = v;
              rp -= 4;
            end
          end
          OPC_MSTORE: ok = sto4(gr[4] + gr[0], acc);
          OPC_MLOAD: begin
            ok = get4(gr[4] + gr[0], v);
            if (ok) acc = v;
          end
          OPC_LOOP, OPC_ZLOOP: begin
            ok  = jump_fwd(acc == 0);
            adv = 0;
          end
          OPC_CLOSE: begin
            ok  = jump_back(acc != 0);
            adv = 0;
          end
          OPC_BACK: begin
            ok  = jump_back(acc == 0);
            adv = 0;
          end
          OPC_SPACE, OPC_TAB, OPC_NL, OPC_BRK: ;
          OPC_HALT: begin
            stat = STAT_HALT;
            adv  = 0;
          end
          default: begin
            stat = STAT_BADOP;
            adv  = 0;
          end
        endcase
      end
      if (!ok) begin
        stat = STAT_FAULT;
        return;
      end
      if (adv) pc++;
    endfunction

    // Applies one accepted transaction and queues the result it should give.
    function void note_request(req_t r);
      bit [7:0] chr;
      bit       vld;
      res_t     e;
      chr = 0;
      vld = 0;
      case (r.req_type)
        REQ_WRITE:   mem[r.write_addr] = r.write_byte;
        REQ_RESTART: restart_core();
        REQ_STEP:    if (stat == STAT_RUN) run_one(chr, vld);
        default: ;
      endcase
      e.out_char   = chr;
      e.char_valid = vld;
      e.run_status = stat;
      e.accu_now   = acc;
      e.pc_now     = pc;
      pending_results.push_back(e);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: mismatch: %s", $time, what);
    endfunction

    function void check_result(res_t got);
      res_t e;
      results_seen++;
      if (pending_results.size() == 0) begin
        flag($sformatf("result %p arrived with none outstanding", got));
        return;
      end
      e = pending_results.pop_front();
      if (got.out_char !== e.out_char)
        flag($sformatf("out_char exp %02h got %02h", e.out_char, got.out_char));
      if (got.char_valid !== e.char_valid)
        flag($sformatf("char_valid exp %0b got %0b", e.char_valid, got.char_valid));
      if (got.run_status !== e.run_status)
        flag($sformatf("run_status exp %0d got %0d", e.run_status, got.run_status));
      if (got.accu_now !== e.accu_now)
        flag($sformatf("accu_now exp %08h got %08h", e.accu_now, got.accu_now));
      if (got.pc_now !== e.pc_now)
        flag($sformatf("pc_now exp %08h got %08h", e.pc_now, got.pc_now));
      if (e.char_valid) chars_seen++;
      stat_seen[e.run_status]++;
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  req_t             req;
  logic             busy;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             done;
  res_t             result;

  machine_tracker sb;
  int             idle_pct;
  int             items_sent;
  string          op_pool = "0123456789abcdefpPijklmnIJKLMNsSD+-AOX~<>rR!@_. BH";
  string          hex_chars = "0123456789abcdef";

  accumulator_stack_bytecode_core uut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results are checked before the transaction taken at the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_request(req);
    end
  end

  function automatic req_t mk(logic [1:0] kind, logic [11:0] addr, logic [7:0] b);
    req_t r;
    r.req_type   = kind;
    r.write_addr = addr;
    r.write_byte = b;
    return r;
  endfunction

  // Offers one transaction after a random idle gap and waits until it is taken.
  task automatic send_item(input req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  function automatic logic [7:0] random_op();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 8'($urandom_range(255));
    if (r < 5) return r[0] ? OPC_TAB : OPC_NL;
    return op_pool[$urandom_range(op_pool.len() - 1)];
  endfunction

  // A random program with bracketed loops, written at the start address and then run.
  task automatic run_program();
    logic [7:0] prog [$];
    logic [11:0] base;
    int steps;
    if ($urandom_range(1)) prog.push_back(OPC_CLR);
    repeat ($urandom_range(0, 4)) prog.push_back(hex_chars[$urandom_range(15)]);
    repeat ($urandom_range(3, 14)) begin
      if ($urandom_range(99) < 25) begin
        prog.push_back($urandom_range(3) == 0 ? OPC_ZLOOP : OPC_LOOP);
        if ($urandom_range(99) < 80) repeat (4) prog.push_back("0");
        else repeat (4) prog.push_back(hex_chars[$urandom_range(15)]);
        repeat ($urandom_range(1, 6)) prog.push_back(random_op());
        prog.push_back($urandom_range(4) == 0 ? OPC_BACK : OPC_CLOSE);
        repeat (4) prog.push_back("0");
      end else begin
        prog.push_back(random_op());
      end
    end
    prog.push_back(OPC_HALT);
    base = sb.pstart[11:0];
    foreach (prog[k]) send_item(mk(REQ_WRITE, base + k[11:0], prog[k]));
    send_item(mk(REQ_RESTART, 12'($urandom), 8'($urandom)));
    steps = prog.size() + $urandom_range(4, 24);
    repeat (steps) begin
      if ($urandom_range(99) < 6)
        send_item(mk(2'($urandom), 12'($urandom), 8'($urandom)));
      send_item(mk(REQ_STEP, 12'($urandom), 8'($urandom)));
    end
  endtask

  initial begin
    logic [7:0] demo [$];
    int phase_pct [4];
    logic [11:0] cfg_set [3][3];
    int target;
    sb         = new();
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SBASE;
    cfg_data   = '0;
    idle_pct   = 0;
    items_sent = 0;
    phase_pct  = '{0, 66, 0, 24};
    cfg_set    = '{'{12'd5, 12'd100, 12'd256}, '{12'd4095, 12'd0, 12'd4095},
                   '{12'd0, 12'd4095, 12'd0}};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: sign-extended add, print, forward scan with write-back, bad opcode,
    // step while stopped and an ignored request.
    demo = '{"8", "0", OPC_SPUSH, OPC_ADD, OPC_EMIT, OPC_CLR, OPC_LOOP, "0", "0", "0",
             "0", OPC_CLOSE, "0", "0", "0", "0", BAD_OPCODE};
    foreach (demo[k]) send_item(mk(REQ_WRITE, PSTART_RST + k[11:0], demo[k]));
    send_item(mk(REQ_RESTART, 12'hfff, 8'hff));
    repeat (9) send_item(mk(REQ_STEP, 12'h000, 8'h00));
    send_item(mk(REQ_NONE, 12'hfff, 8'hff));

    // Random programs under a series of register settings and idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 3; k++)
        write_reg(2'(k), ph < 3 ? cfg_set[ph][k] : 12'($urandom));
      if (ph >= 3 && $urandom_range(1)) write_reg(CFG_PSTART, 12'($urandom_range(0, 3800)));
      idle_pct = phase_pct[ph % 4];
      target   = 240 * (ph + 1);
      while (items_sent < target) begin
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(1, 6)) send_item(mk(2'($urandom), 12'($urandom), 8'($urandom)));
        else run_program();
      end
    end

    settle();
    $display("Ran %0d transactions over eight register settings; %0d results checked.",
             items_sent, sb.results_seen);
    $display("Characters printed %0d; halts %0d, bad opcodes %0d, access faults %0d.",
             sb.chars_seen, sb.stat_seen[STAT_HALT], sb.stat_seen[STAT_BADOP],
             sb.stat_seen[STAT_FAULT]);
    if (sb.mismatches == 0) begin
      $display("accumulator_stack_bytecode_core regression: pass");
    end else begin
      $display("%0d mismatches in total.", sb.mismatches);
      $display("accumulator_stack_bytecode_core regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1_000_000_000;
    $display("Timed out with %0d results outstanding.", sb.pending_results.size());
    $display("accumulator_stack_bytecode_core regression: fail");
    $finish;
  end

endmodule
